// File: design/fbpa_pkg.sv
// Package for the fixed block pool allocator: request and response types,
// operation and status codes, field widths and parameter defaults.
// It depends on nothing else in the project.
package fbpa_pkg;

    // Field widths fixed by the interface.
    localparam int IDX_W    = 8;
    localparam int SIZE_W   = 16;
    localparam int LINK_W   = IDX_W + 1;
    localparam int LINK_DEPTH = 1 << IDX_W;
    localparam int FRESH_W  = IDX_W + 1;

    // Default geometry of the pools.
    localparam int DEF_BLOCKS_PER_POOL = 16;
    localparam int DEF_MAX_POOLS       = 16;

    // Reset value of the block size register.
    localparam logic [SIZE_W-1:0] BLOCK_SIZE_RESET = 16'd64;

    // Operation codes.
    localparam logic [1:0] OP_ALLOCATE = 2'd0;
    localparam logic [1:0] OP_RESIZE   = 2'd1;
    localparam logic [1:0] OP_FREE     = 2'd2;
    localparam logic [1:0] OP_RESET    = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [SIZE_W-1:0] request_size;
        logic [IDX_W-1:0]  block_index;
    } alloc_req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] granted_index;
        logic             pool_opened;
    } alloc_rsp_t;

endpackage

// File: design/fixed_block_pool_allocator_core.sv
// Fixed block pool allocator: each accepted request's response is registered in
// the output register or skid stage; one request per cycle while skid is empty.
// The link store read is registered and addressed by the next free-list head,
// so a pop in every cycle finds the successor link ready.
// Reset clears all control state and the block size returns to 64; the link
// store is not cleared, since an entry is only read after a free has written it.
// Depends on fbpa_pkg.
module fixed_block_pool_allocator_core #(
    parameter int BLOCKS_PER_POOL = fbpa_pkg::DEF_BLOCKS_PER_POOL,
    parameter int MAX_POOLS       = fbpa_pkg::DEF_MAX_POOLS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [fbpa_pkg::SIZE_W-1:0]  cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  fbpa_pkg::alloc_req_t         in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output fbpa_pkg::alloc_rsp_t         out_data
);
    import fbpa_pkg::*;

    localparam int TOTAL_BLOCKS = (BLOCKS_PER_POOL * MAX_POOLS > LINK_DEPTH)
                                  ? LINK_DEPTH : BLOCKS_PER_POOL * MAX_POOLS;
    localparam int OFS_W  = (BLOCKS_PER_POOL > 1) ? $clog2(BLOCKS_PER_POOL) : 1;
    localparam int POOL_W = $clog2(MAX_POOLS + 1);
    localparam logic [FRESH_W-1:0] TOTAL_LIM = FRESH_W'(TOTAL_BLOCKS);
    localparam logic [OFS_W-1:0]   OFS_LAST  = OFS_W'(BLOCKS_PER_POOL - 1);
    localparam logic [POOL_W-1:0]  POOL_LIM  = POOL_W'(MAX_POOLS);

    // Control state.
    logic [SIZE_W-1:0]  block_size_reg;
    logic [IDX_W-1:0]   free_head_reg, free_head_next;
    logic               nonempty_reg, nonempty_next;
    logic [FRESH_W-1:0] fresh_reg, fresh_next;
    logic [OFS_W-1:0]   pool_ofs_reg, pool_ofs_next;
    logic [POOL_W-1:0]  fresh_pool_reg, fresh_pool_next;
    logic [POOL_W-1:0]  pools_open_reg, pools_open_next;
    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;

    // Payload state.
    logic [LINK_W-1:0]  link_mem [LINK_DEPTH];
    logic [LINK_W-1:0]  link_rd_reg;
    alloc_rsp_t         out_data_reg, skid_data_reg;

    logic               accept;
    logic               out_fire;
    logic               too_large;
    logic               link_we;
    logic [LINK_W-1:0]  link_wdata;
    alloc_rsp_t         rsp;

    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign too_large = in_data.request_size > block_size_reg;

    // A free links the pushed block to the current head.
    assign link_we    = accept && (in_data.opcode == OP_FREE);
    assign link_wdata = {nonempty_reg, free_head_reg};

    // Operation decode: response and next allocator state.
    always_comb
    begin
        free_head_next  = free_head_reg;
        nonempty_next   = nonempty_reg;
        fresh_next      = fresh_reg;
        pool_ofs_next   = pool_ofs_reg;
        fresh_pool_next = fresh_pool_reg;
        pools_open_next = pools_open_reg;
        rsp             = '{status: ST_OK, granted_index: '0, pool_opened: 1'b0};
        if (accept)
        begin
            unique case (in_data.opcode)
                OP_ALLOCATE:
                begin
                    if (too_large)
                    begin
                        rsp.status = ST_TOO_LARGE;
                    end
                    else if (nonempty_reg)
                    begin
                        rsp.granted_index = free_head_reg;
                        free_head_next    = link_rd_reg[IDX_W-1:0];
                        nonempty_next     = link_rd_reg[LINK_W-1];
                    end
                    else if (fresh_reg >= TOTAL_LIM)
                    begin
                        rsp.status = ST_EXHAUSTED;
                    end
                    else
                    begin
                        rsp.granted_index = fresh_reg[IDX_W-1:0];
                        if (fresh_pool_reg >= pools_open_reg)
                        begin
                            pools_open_next = fresh_pool_reg + 1'b1;
                            rsp.pool_opened = 1'b1;
                        end
                        fresh_next = fresh_reg + 1'b1;
                        if (pool_ofs_reg == OFS_LAST)
                        begin
                            pool_ofs_next   = '0;
                            fresh_pool_next = fresh_pool_reg + 1'b1;
                        end
                        else
                        begin
                            pool_ofs_next = pool_ofs_reg + 1'b1;
                        end
                    end
                end
                OP_RESIZE:
                begin
                    if (too_large)
                        rsp.status = ST_TOO_LARGE;
                    else
                        rsp.granted_index = in_data.block_index;
                end
                OP_FREE:
                begin
                    free_head_next    = in_data.block_index;
                    nonempty_next     = 1'b1;
                    rsp.granted_index = in_data.block_index;
                end
                OP_RESET:
                begin
                    free_head_next  = '0;
                    nonempty_next   = 1'b0;
                    fresh_next      = '0;
                    pool_ofs_next   = '0;
                    fresh_pool_next = '0;
                end
                default:
                begin
                    rsp.status = ST_OK;
                end
            endcase
        end
    end

    // Output register with a skid stage behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_fire)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept;
            end
        end
        else if (!out_valid_reg)
        begin
            out_valid_next = accept;
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= BLOCK_SIZE_RESET;
            free_head_reg  <= '0;
            nonempty_reg   <= 1'b0;
            fresh_reg      <= '0;
            pool_ofs_reg   <= '0;
            fresh_pool_reg <= '0;
            pools_open_reg <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                block_size_reg <= cfg_data;
            free_head_reg  <= free_head_next;
            nonempty_reg   <= nonempty_next;
            fresh_reg      <= fresh_next;
            pool_ofs_reg   <= pool_ofs_next;
            fresh_pool_reg <= fresh_pool_next;
            pools_open_reg <= pools_open_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Response payload registers.
    always_ff @(posedge clk)
    begin
        if (out_fire && skid_valid_reg)
            out_data_reg <= skid_data_reg;
        else if (out_fire || !out_valid_reg)
            out_data_reg <= rsp;
        if (accept && out_valid_reg && !out_fire)
            skid_data_reg <= rsp;
    end

    // Link store: the read follows the next head, with the link being
    // written forwarded, so the register always holds the head's successor.
    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[in_data.block_index] <= link_wdata;
        if (link_we && (in_data.block_index == free_head_next))
            link_rd_reg <= link_wdata;
        else
            link_rd_reg <= link_mem[free_head_next];
    end

    // The skid stage only fills behind a waiting response.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a response while the output is empty");

    // A free always leaves the list non-empty, pointing at the freed block.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.opcode == OP_FREE) |=>
        (nonempty_reg && free_head_reg == $past(in_data.block_index)))
        else $error("free did not push the block on the list");

    // The fresh pointer never runs past the total number of blocks.
    assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= TOTAL_LIM)
        else $error("fresh pointer beyond the last block");

    // No more pools are opened than exist, and the fresh pool is within them.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pools_open_reg <= POOL_LIM) && (fresh_pool_reg <= POOL_LIM))
        else $error("pool count beyond the number of pools");

    // Opening a pool raises the count by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && rsp.pool_opened) |=> (pools_open_reg == $past(pools_open_reg) + 1'b1))
        else $error("pool opened without the count stepping by one");

endmodule

// File: tb/fbpa_response_checker.sv
// Response checker for the fixed block pool allocator: predicts every response
// from the accepted requests and register writes, and compares in order.
// Depends on fbpa_pkg for the request and response types and codes.
module fbpa_response_checker #(
    parameter int BLOCKS_PER_POOL = fbpa_pkg::DEF_BLOCKS_PER_POOL,
    parameter int MAX_POOLS       = fbpa_pkg::DEF_MAX_POOLS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [fbpa_pkg::SIZE_W-1:0] cfg_data,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  fbpa_pkg::alloc_req_t        in_data,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  fbpa_pkg::alloc_rsp_t        out_data,
    output int                          fail_count,
    output int                          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import fbpa_pkg::*;

    localparam int ALL_BLOCKS = (BLOCKS_PER_POOL * MAX_POOLS > LINK_DEPTH) ?
                                LINK_DEPTH : BLOCKS_PER_POOL * MAX_POOLS;

    // Shadow of the allocator state.
    logic [SIZE_W-1:0]  size_limit;
    logic [IDX_W-1:0]   list_top;
    logic               list_filled;
    logic [LINK_W-1:0]  successor [LINK_DEPTH];
    logic [FRESH_W-1:0] fresh_block;
    int                 pools_in_use;

    alloc_rsp_t predicted_rsps [$];

    // Works out the response to one request and advances the shadow state.
    function automatic alloc_rsp_t predict_grant(input alloc_req_t req);
        alloc_rsp_t         rsp;
        logic [LINK_W-1:0]  link;
        int                 pool;
        rsp = '0;
        rsp.status = ST_OK;
        case (req.opcode)
            OP_ALLOCATE:
            begin
                if (req.request_size > size_limit)
                begin
                    rsp.status = ST_TOO_LARGE;
                end
                else if (list_filled)
                begin
                    link = successor[list_top];
                    rsp.granted_index = list_top;
                    list_top = link[IDX_W-1:0];
                    list_filled = link[IDX_W];
                end
                else if (int'(fresh_block) >= ALL_BLOCKS)
                begin
                    rsp.status = ST_EXHAUSTED;
                end
                else
                begin
                    // A never-used block; the first one of a pool opens it.
                    pool = int'(fresh_block) / BLOCKS_PER_POOL;
                    rsp.granted_index = fresh_block[IDX_W-1:0];
                    if (pool >= pools_in_use)
                    begin
                        pools_in_use = pool + 1;
                        rsp.pool_opened = 1'b1;
                    end
                    fresh_block = fresh_block + 1'b1;
                end
            end
            OP_RESIZE:
            begin
                if (req.request_size > size_limit)
                    rsp.status = ST_TOO_LARGE;
                else
                    rsp.granted_index = req.block_index;
            end
            OP_FREE:
            begin
                successor[req.block_index] = {list_filled, list_top};
                list_top = req.block_index;
                list_filled = 1'b1;
                rsp.granted_index = req.block_index;
            end
            default:
            begin
                // Reset of all blocks: the opened pools stay open.
                list_top = '0;
                list_filled = 1'b0;
                fresh_block = '0;
            end
        endcase
        return rsp;
    endfunction

    task automatic note_mismatch(input string field, input int want, input int got);
        fail_count++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                 $time, field, want, got);
    endtask

    // Compare accepted responses first, since a response never belongs to the
    // request accepted at the same edge, then predict the new request. A
    // register write at the same edge only affects later requests.
    always @(posedge clk or negedge rst_n)
    begin
        alloc_rsp_t want;
        if (!rst_n)
        begin
            size_limit = BLOCK_SIZE_RESET;
            list_top = '0;
            list_filled = 1'b0;
            fresh_block = '0;
            pools_in_use = 0;
            foreach (successor[i])
                successor[i] = '0;
            predicted_rsps.delete();
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_rsps.size() == 0)
                begin
                    fail_count++;
                    $display("%0t ns: response transaction with none expected, actual %p",
                             $time, out_data);
                end
                else
                begin
                    want = predicted_rsps.pop_front();
                    if (out_data.status !== want.status)
                        note_mismatch("status", want.status, out_data.status);
                    if (out_data.granted_index !== want.granted_index)
                        note_mismatch("granted_index", want.granted_index,
                                      out_data.granted_index);
                    if (out_data.pool_opened !== want.pool_opened)
                        note_mismatch("pool_opened", want.pool_opened,
                                      out_data.pool_opened);
                end
            end
            if (in_valid && in_ready)
                predicted_rsps.push_back(predict_grant(in_data));
            if (cfg_we)
                size_limit = cfg_data;
            outstanding <= predicted_rsps.size();
        end
    end

endmodule

// File: tb/fixed_block_pool_allocator_core_test.sv
// Top-level testbench for the fixed block pool allocator: clock, reset,
// request and register stimulus, response back-pressure and the verdict.
// Depends on fbpa_pkg, the allocator core and fbpa_response_checker.
module fixed_block_pool_allocator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fbpa_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int LONG_HOLD_AT     = 40;
    localparam int LONG_HOLD_CYCLES = 60;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [SIZE_W-1:0] cfg_data  = '0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    alloc_req_t        in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    alloc_rsp_t        out_data;

    int fail_count;
    int outstanding;

    // Stimulus bookkeeping.
    logic [SIZE_W-1:0] cur_block_size = BLOCK_SIZE_RESET;
    logic              calm           = 1'b0;
    int                send_gap_pct   = 0;
    int                gap_window     = 0;
    int                rsp_count      = 0;
    int                cycle_count    = 0;
    logic [1:0]        ops_in_flight [$];
    logic [IDX_W-1:0]  held_blocks [$];

    fixed_block_pool_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    fbpa_response_checker response_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // Watchdog on the run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Track which blocks the allocator has handed out, so that frees can
    // mostly return real allocations. Handshake signals are stable between
    // edges, so sampling at the falling edge sees the coming transactions.
    always @(negedge clk)
    begin
        logic [1:0] done_op;
        if (rst_n && out_valid && out_ready && ops_in_flight.size() != 0)
        begin
            done_op = ops_in_flight.pop_front();
            rsp_count++;
            if (done_op == OP_ALLOCATE && out_data.status == ST_OK)
                held_blocks.push_back(out_data.granted_index);
            else if (done_op == OP_RESET)
                held_blocks.delete();
        end
        if (rst_n && in_valid && in_ready)
            ops_in_flight.push_back(in_data.opcode);
    end

    // Response back-pressure: random stall bursts in windows of varying
    // intensity, and one long hold so that the block fills up.
    initial
    begin
        int stall_pct;
        int window_left;
        bit long_hold_done;
        stall_pct = 0;
        window_left = 0;
        long_hold_done = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (window_left == 0)
            begin
                window_left = 100;
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 35;
                endcase
            end
            window_left--;
            if (!long_hold_done && rsp_count >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Offers one request transaction and returns at the edge that accepts it.
    task automatic send_req(input alloc_req_t req);
        if (gap_window == 0)
        begin
            gap_window = 32;
            case ($urandom_range(0, 2))
                0: send_gap_pct = 0;
                1: send_gap_pct = 15;
                default: send_gap_pct = 40;
            endcase
        end
        gap_window--;
        if (!calm && $urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic issue(input logic [1:0] op, input logic [SIZE_W-1:0] size,
                         input logic [IDX_W-1:0] idx);
        alloc_req_t req;
        req.opcode = op;
        req.request_size = size;
        req.block_index = idx;
        send_req(req);
    endtask

    // Stops offering requests until every response has come back.
    task automatic drain_responses();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Register write; only called while the block is idle.
    task automatic set_block_size(input logic [SIZE_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        cur_block_size = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random request. The fill mix is nearly all allocates so that every pool
    // opens and the allocator runs dry; the normal mix frees mostly real
    // allocations and resets the blocks now and then.
    function automatic alloc_req_t make_request(input bit fill_mix);
        alloc_req_t req;
        int roll;
        int pick;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            req.request_size = SIZE_W'($urandom_range(0, cur_block_size));
        else if (roll < 90 && cur_block_size != '1)
            req.request_size = cur_block_size + 1'b1;
        else
            req.request_size = SIZE_W'($urandom);
        req.block_index = IDX_W'($urandom_range(0, 255));
        req.opcode = OP_ALLOCATE;
        roll = $urandom_range(0, 99);
        if (fill_mix)
        begin
            if (roll >= 98)
                req.opcode = OP_FREE;
            else if (roll >= 95)
                req.opcode = OP_RESIZE;
        end
        else if (roll >= 96)
        begin
            req.opcode = OP_RESET;
        end
        else if (roll >= 78)
        begin
            req.opcode = OP_RESIZE;
            if (held_blocks.size() != 0 && $urandom_range(0, 1) == 0)
                req.block_index = held_blocks[$urandom_range(0, held_blocks.size() - 1)];
        end
        else if (roll >= 45)
        begin
            req.opcode = OP_FREE;
            if (held_blocks.size() != 0 && $urandom_range(0, 3) != 0)
            begin
                pick = $urandom_range(0, held_blocks.size() - 1);
                req.block_index = held_blocks[pick];
                held_blocks.delete(pick);
            end
        end
        return req;
    endfunction

    // Main sequence: reset, directed cases, then random phases.
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases at the reset block size.
        issue(OP_ALLOCATE, 16'd0, 8'd0);        // first fresh block opens a pool
        issue(OP_ALLOCATE, 16'd64, 8'hFF);      // exactly the block size
        issue(OP_ALLOCATE, 16'd65, 8'd0);       // request too large
        issue(OP_RESIZE, 16'hFFFF, 8'hFF);      // resize too large
        issue(OP_RESIZE, 16'd64, 8'hFF);        // resize keeps the index
        issue(OP_FREE, 16'hFFFF, 8'd1);
        issue(OP_FREE, 16'd0, 8'd0);
        issue(OP_ALLOCATE, 16'd1, 8'd0);        // last freed comes back first
        issue(OP_ALLOCATE, 16'd1, 8'd0);
        issue(OP_ALLOCATE, 16'd1, 8'd0);        // list empty again, next fresh
        issue(OP_FREE, 16'd0, 8'hFF);           // never handed out
        issue(OP_FREE, 16'd0, 8'hFF);           // already free
        issue(OP_ALLOCATE, 16'd2, 8'd0);
        issue(OP_ALLOCATE, 16'd2, 8'd0);
        issue(OP_RESET, 16'hFFFF, 8'hFF);
        issue(OP_ALLOCATE, 16'd3, 8'd0);        // rewound, pool already open
        drain_responses();

        // A zero block size only admits empty requests.
        set_block_size(16'd0);
        issue(OP_ALLOCATE, 16'd0, 8'd0);
        issue(OP_ALLOCATE, 16'd1, 8'd0);
        issue(OP_RESIZE, 16'd0, 8'hAA);
        drain_responses();
        set_block_size(16'd1);
        issue(OP_ALLOCATE, 16'd1, 8'd0);
        issue(OP_RESIZE, 16'd2, 8'h55);
        drain_responses();

        // Mixed traffic; halfway the sender waits for every response.
        set_block_size(16'd64);
        for (int i = 0; i < 110; i++)
        begin
            if (i == 55)
                drain_responses();
            send_req(make_request(1'b0));
        end
        drain_responses();

        // Allocate until every pool is open and the blocks run out.
        set_block_size(16'hFFFF);
        for (int i = 0; i < 290; i++)
            send_req(make_request(1'b1));
        drain_responses();

        // Final stretch with no idling on either side.
        set_block_size(SIZE_W'($urandom_range(2, 65534)));
        calm <= 1'b1;
        for (int i = 0; i < 100; i++)
            send_req(make_request(1'b0));
        drain_responses();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
design/fbpa_pkg.sv
design/fixed_block_pool_allocator_core.sv
tb/fbpa_response_checker.sv
tb/fixed_block_pool_allocator_core_test.sv
